// ===== rtl/i2sfmt_pkg.sv =====
// Shared types and constants for the stereo sample formatter with PDM mode.
// Depends on nothing; imported by i2s_sample_formatter_pdm.
package i2sfmt_pkg;

  // Width of one audio sample and of one transmit word.
  localparam int unsigned SampleW = 16;
  localparam int unsigned WordW   = 32;

  // Number of modulator steps run for one sample pair.
  localparam int unsigned PdmBits = 32;

  // Lane arithmetic for the closed-form modulator: n*d + ~e stays below
  // (PdmBits + 1) * 2^16, and the running count of ones fits in QuotW bits.
  localparam int unsigned LaneW = $clog2((PdmBits + 1) * (1 << SampleW));
  localparam int unsigned QuotW = LaneW - SampleW;

  // Modulator output shift register, wide enough for one transmit word.
  localparam int unsigned ShiftW = WordW;

  localparam logic [SampleW-1:0] FullScale = '1;

  typedef enum logic [1:0] {
    FmtPhilips = 2'd0,
    FmtLeftJust = 2'd1,
    FmtPdm = 2'd2
  } format_mode_e;

  typedef logic [1:0] mode_reg_t;

  // The one mode code without a mode: it sends zero and keeps all state.
  localparam mode_reg_t ModeUnused = 2'd3;

endpackage

// ===== rtl/i2s_sample_formatter_pdm.sv =====
// Stereo sample formatter: Philips packing, left-justified with a one-beat
// delay, or first-order sigma-delta PDM. Depends on i2sfmt_pkg.
//
//   channel   dir   handshake               payload
//   cfg       in    cfg_valid_i/cfg_ready_o cfg_format_mode_i [1:0]
//   in        in    in_valid_i/in_ready_o   left_sample_i, right_sample_i
//   out       out   out_valid_o/out_ready_i tx_word_o [31:0]
//
// Each input beat is formatted combinationally and registered at the edge
// that accepts it: into the output register if that is empty or being read,
// else into the one-entry skid register behind it, so one further beat is
// still taken while a result waits. A new beat can be taken every cycle while
// the skid is empty; input ready is the registered "skid empty" flag.
// Reset is asynchronous and active low. It clears the mode register (Philips),
// the delayed left-justified word, the modulator error accumulator and the
// modulator shift register, and empties both output slots.
// The cfg channel is always ready; the mode must only change while idle.
//
// The PDM mode does not iterate. The step rule e' = e - d + 65535*b keeps e in
// 1..65535 for any d below full scale, so the count of ones after n steps is
// ceil((n*d - e0 + 1) / 65535). Every step has its own lane that works out this
// count in parallel, and each output bit is the change of the count between
// neighboring lanes. A full-scale d gives all ones and leaves e unchanged.
module i2s_sample_formatter_pdm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  i2sfmt_pkg::mode_reg_t                cfg_format_mode_i,
  // Sample pair input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [i2sfmt_pkg::SampleW-1:0] left_sample_i,
  input  logic signed [i2sfmt_pkg::SampleW-1:0] right_sample_i,
  // Transmit word output channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [i2sfmt_pkg::WordW-1:0]         tx_word_o
);
  import i2sfmt_pkg::*;

  // Configuration and per-mode state.
  mode_reg_t          mode_q;
  logic [WordW-1:0]   delayed_q, delayed_d;
  logic [SampleW-1:0] err_q, err_d;
  logic [ShiftW-1:0]  shift_q, shift_d;

  // Output register and skid register.
  logic               out_valid_q, out_valid_d;
  logic [WordW-1:0]   tx_word_q, tx_word_d;
  logic               skid_valid_q, skid_valid_d;
  logic [WordW-1:0]   skid_word_q, skid_word_d;

  logic in_fire;
  logic out_fire;
  logic [WordW-1:0] word;

  // Channel average, truncated toward minus infinity, as an unsigned 16-bit code.
  logic [SampleW:0]   pair_sum;
  logic [SampleW-1:0] avg;

  // Closed-form modulator lanes.
  logic [LaneW-1:0]   lane_y   [1:PdmBits];
  logic [QuotW-1:0]   lane_cnt [0:PdmBits];
  logic [PdmBits-1:0] pdm_bits;
  logic [SampleW-1:0] pdm_err_next;
  logic [ShiftW+PdmBits-1:0] pdm_full;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign tx_word_o   = tx_word_q;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_q & out_ready_i;

  assign pair_sum = {left_sample_i[SampleW-1], left_sample_i}
                  + {right_sample_i[SampleW-1], right_sample_i};
  assign avg      = pair_sum[SampleW:1];

  // Lane n holds n*d + (65535 - e0); its quotient by 65535 is the number of
  // ones after n steps. The quotient needs one correction at most.
  assign lane_cnt[0] = '0;
  for (genvar n = 1; n <= PdmBits; n++) begin : g_lane
    logic [QuotW-1:0]   q0;
    logic [SampleW:0]   rem;
    assign lane_y[n] = LaneW'(n) * LaneW'(avg) + LaneW'(FullScale - err_q);
    assign q0        = lane_y[n][LaneW-1:SampleW];
    assign rem       = {1'b0, lane_y[n][SampleW-1:0]} + (SampleW+1)'(q0);
    assign lane_cnt[n] = q0 + QuotW'(rem >= {1'b0, FullScale});
  end

  // The oldest step lands in the top bit of the new group.
  for (genvar k = 0; k < PdmBits; k++) begin : g_bit
    assign pdm_bits[PdmBits-1-k] = (avg == FullScale) ? 1'b1
                                 : (lane_cnt[k+1] != lane_cnt[k]);
  end

  assign pdm_err_next = (avg == FullScale) ? err_q
                      : err_q - SampleW'(32'(avg) * PdmBits)
                              - SampleW'(lane_cnt[PdmBits]);
  assign pdm_full = {shift_q, pdm_bits};

  // Formatting and state update for the beat being accepted.
  always_comb begin
    word      = '0;
    delayed_d = delayed_q;
    err_d     = err_q;
    shift_d   = shift_q;
    unique case (mode_q)
      FmtPhilips: begin
        word = {right_sample_i, left_sample_i};
      end
      FmtLeftJust: begin
        word      = {delayed_q[WordW-1:1], right_sample_i[SampleW-1]};
        delayed_d = {right_sample_i[SampleW-2:0], left_sample_i, 1'b0};
      end
      FmtPdm: begin
        word    = pdm_full[WordW-1:0];
        err_d   = pdm_err_next;
        shift_d = pdm_full[ShiftW-1:0];
      end
      default: begin
        word = '0;
      end
    endcase
  end

  // Output register with a one-entry skid behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    tx_word_d    = tx_word_q;
    skid_valid_d = skid_valid_q;
    skid_word_d  = skid_word_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        tx_word_d    = skid_word_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = 1'b1;
        tx_word_d   = word;
      end else begin
        skid_valid_d = 1'b1;
        skid_word_d  = word;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= FmtPhilips;
      delayed_q    <= '0;
      err_q        <= '0;
      shift_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_format_mode_i;
      end
      if (in_fire) begin
        delayed_q <= delayed_d;
        err_q     <= err_d;
        shift_q   <= shift_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_word_q   <= tx_word_d;
    skid_word_q <= skid_word_d;
  end

  // The skid slot only fills behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register is empty");

  // A Philips beat that goes straight to the output shows its packed pair.
  a_philips_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q == FmtPhilips && (!out_valid_q || out_ready_i))
    |=> tx_word_q == $past({right_sample_i, left_sample_i}))
    else $error("Philips word does not match the accepted pair");

  // The unused mode code leaves every mode's state alone.
  a_unused_mode_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q == ModeUnused)
    |=> ($stable(err_q) && $stable(delayed_q) && $stable(shift_q)))
    else $error("unused mode changed formatter state");

  // A full-scale average neither moves the error accumulator nor emits zeros.
  a_pdm_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q == FmtPdm && avg == FullScale)
    |=> ($stable(err_q) && shift_q[PdmBits-1:0] == '1))
    else $error("full-scale PDM step changed the error or produced a zero");

  // Only the left-justified mode may change the delayed word.
  a_delay_only_lj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q != FmtLeftJust) |=> $stable(delayed_q))
    else $error("delayed word changed outside left-justified mode");

endmodule
